// ===== hdl/klt_pkg.sv =====
package klt_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_PLACE,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_CMP,
		ST_DONE
	} klt_state_t;

	// Result handed from the heap engine to the output register.
	typedef struct packed {
		logic               done;
		logic signed [31:0] kth_value;
		logic               filled;
	} klt_result_t;

	localparam int unsigned CfgWidth = 7;

endpackage

// ===== hdl/klt_heap_mem.sv =====
module klt_heap_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read: rdata updates only when re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/klt_heap_engine.sv =====
module klt_heap_engine #(
	parameter int unsigned MAX_KEEP = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic signed [31:0]    value,
	output logic                  item_stall,
	input  logic [$clog2(MAX_KEEP+1)-1:0] k_eff,
	input  logic                  slot_free,
	output klt_pkg::klt_result_t  res
);

	localparam int unsigned CW = $clog2(MAX_KEEP + 1);
	localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	klt_pkg::klt_state_t state_q, state_d;

	logic [CW-1:0]      total_q;
	logic [CW-1:0]      cur_q;
	logic signed [31:0] x_q;
	logic signed [31:0] root_q;
	logic signed [31:0] lval_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;

	logic               accept;
	logic               push;
	logic               discard;
	logic [CW-1:0]      par;
	logic [CW:0]        lidx;
	logic [CW:0]        ridx;
	logic               l_ok;
	logic               r_ok;
	logic               use_r;
	logic signed [31:0] cval;
	logic [CW-1:0]      cidx;

	klt_heap_mem #(
		.DEPTH(MAX_KEEP),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign accept  = item_valid && (state_q == klt_pkg::ST_IDLE);
	assign push    = total_q < k_eff;
	// full set and the new value is no larger than the minimum: drop it
	assign discard = !push && (value <= root_q);

	assign par   = (cur_q - CW'(1)) >> 1;
	assign lidx  = {cur_q, 1'b1};
	assign ridx  = lidx + (CW+1)'(1);
	assign l_ok  = lidx < {1'b0, total_q};
	assign r_ok  = ridx < {1'b0, total_q};
	assign use_r = r_ok && (mem_rdata < lval_q);
	assign cval  = use_r ? mem_rdata : lval_q;
	assign cidx  = use_r ? ridx[CW-1:0] : lidx[CW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			klt_pkg::ST_IDLE: begin
				if (accept) begin
					if (push) begin
						state_d = (total_q == '0) ? klt_pkg::ST_DONE : klt_pkg::ST_UP_RD;
					end else if (discard) begin
						state_d = klt_pkg::ST_DONE;
					end else begin
						state_d = klt_pkg::ST_DN_RDL;
					end
				end
			end
			klt_pkg::ST_UP_RD:  state_d = klt_pkg::ST_UP_CMP;
			klt_pkg::ST_UP_CMP: begin
				if (mem_rdata > x_q) begin
					state_d = (par == '0) ? klt_pkg::ST_PLACE : klt_pkg::ST_UP_RD;
				end else begin
					state_d = klt_pkg::ST_DONE;
				end
			end
			klt_pkg::ST_PLACE:  state_d = klt_pkg::ST_DONE;
			klt_pkg::ST_DN_RDL: state_d = l_ok ? klt_pkg::ST_DN_RDR : klt_pkg::ST_DONE;
			klt_pkg::ST_DN_RDR: state_d = klt_pkg::ST_DN_CMP;
			klt_pkg::ST_DN_CMP: state_d = (cval < x_q) ? klt_pkg::ST_DN_RDL : klt_pkg::ST_DONE;
			klt_pkg::ST_DONE:   state_d = slot_free ? klt_pkg::ST_IDLE : klt_pkg::ST_DONE;
			default:            state_d = klt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we        = 1'b0;
		mem_waddr     = cur_q[AW-1:0];
		mem_wdata     = x_q;
		mem_re        = 1'b0;
		mem_raddr     = par[AW-1:0];
		item_stall    = 1'b1;
		res.done      = 1'b0;
		res.kth_value = root_q;
		res.filled    = total_q >= k_eff;
		unique case (state_q)
			klt_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (accept && push && (total_q == '0)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = value;
				end
			end
			klt_pkg::ST_UP_RD: mem_re = 1'b1;
			klt_pkg::ST_UP_CMP: begin
				mem_we = 1'b1;
				if (mem_rdata > x_q) begin
					mem_wdata = mem_rdata;
				end
			end
			klt_pkg::ST_PLACE: mem_we = 1'b1;
			klt_pkg::ST_DN_RDL: begin
				if (l_ok) begin
					mem_re    = 1'b1;
					mem_raddr = lidx[AW-1:0];
				end else begin
					mem_we = 1'b1;
				end
			end
			klt_pkg::ST_DN_RDR: begin
				mem_re    = r_ok;
				mem_raddr = ridx[AW-1:0];
			end
			klt_pkg::ST_DN_CMP: begin
				mem_we = 1'b1;
				if (cval < x_q) begin
					mem_wdata = cval;
				end
			end
			klt_pkg::ST_DONE: res.done = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= klt_pkg::ST_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && push) begin
				total_q <= total_q + CW'(1);
			end
		end
	end

	// root mirrors heap entry zero so the minimum is read without a memory access
	always_ff @(posedge clk) begin
		if (mem_we && (mem_waddr == '0)) begin
			root_q <= mem_wdata;
		end
		unique case (state_q)
			klt_pkg::ST_IDLE: begin
				if (accept) begin
					x_q   <= value;
					cur_q <= push ? total_q : '0;
				end
			end
			klt_pkg::ST_UP_CMP: begin
				if (mem_rdata > x_q) begin
					cur_q <= par;
				end
			end
			klt_pkg::ST_DN_RDR: lval_q <= mem_rdata;
			klt_pkg::ST_DN_CMP: begin
				if (cval < x_q) begin
					cur_q <= cidx;
				end
			end
			default: ;
		endcase
	end

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_KEEP))
		else $error("kept count above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_waddr} < (AW+1)'(total_q)) || (total_q == '0))
		else $error("heap write outside held entries");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + CW'(1)))
		else $error("kept count changed by more than one");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == klt_pkg::ST_DONE) && !slot_free |=> (state_q == klt_pkg::ST_DONE))
		else $error("finished item lost while output full");

endmodule

// ===== hdl/kth_largest_tracker.sv =====
// kth_largest_tracker: keeps the k largest signed 32-bit values of a stream
// and returns, for every input item, the k-th largest so far (kth_value)
// and whether k values are held yet (filled).
//
// Channels: the input item (value) moves when item_valid is high and
// item_stall is low; the result item moves when result_valid is high and
// result_stall is low. keep_count is written when keep_count_we is high and
// should change only while no item is in flight; zero acts as one and values
// above MAX_KEEP saturate to MAX_KEEP.
//
// Timing: the kept values sit in a binary min-heap in one synchronous RAM.
// A dropped value goes from idle straight to the done state. Growing the
// heap sifts up with a read step and a compare step per level; replacing
// the minimum sifts down with a left-child read, a right-child read and a
// compare step per level, as the single RAM read port serialises the reads.
// One item is worked on at a time; the next is taken once the engine is
// idle, even if the last result still waits in the output register.
// Reset clears the held count and sets keep_count to one; the RAM needs no
// clearing pass. A stalled result holds in the output register, and a
// finished item waits inside the engine until that register frees up.
module kth_largest_tracker #(
	parameter int unsigned MAX_KEEP = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               keep_count_we,
	input  logic [6:0]         keep_count,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] kth_value,
	output logic               filled
);

	localparam int unsigned CW = $clog2(MAX_KEEP + 1);

	logic [klt_pkg::CfgWidth-1:0] keep_count_q;
	logic [CW-1:0]                k_eff;
	logic                         slot_free;
	klt_pkg::klt_result_t         res;

	logic               result_valid_q;
	logic signed [31:0] kth_value_q;
	logic               filled_q;

	// hold the configured count; reset to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= klt_pkg::CfgWidth'(1);
		end else if (keep_count_we) begin
			keep_count_q <= keep_count;
		end
	end

	// clamp to the range the heap can hold
	always_comb begin
		if (keep_count_q == '0) begin
			k_eff = CW'(1);
		end else if (32'(keep_count_q) > 32'(MAX_KEEP)) begin
			k_eff = CW'(MAX_KEEP);
		end else begin
			k_eff = CW'(keep_count_q);
		end
	end

	// output slot takes a new result when empty or being drained this cycle
	assign slot_free = !result_valid_q || !result_stall;

	klt_heap_engine #(
		.MAX_KEEP(MAX_KEEP)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.value     (value),
		.item_stall(item_stall),
		.k_eff     (k_eff),
		.slot_free (slot_free),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res.done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// payload loads only when the slot is free, so a stalled result holds
	always_ff @(posedge clk) begin
		if (res.done) begin
			kth_value_q <= res.kth_value;
			filled_q    <= res.filled;
		end
	end

	assign result_valid = result_valid_q;
	assign kth_value    = kth_value_q;
	assign filled       = filled_q;

endmodule
